>>> rtl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg: shared constants for the row softmax block
// Holds the fixed-point constants used by the exp and normalize passes.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int LogitW = 16;
  localparam int ExpW   = 17;
  localparam int SumW   = 23;
  localparam int RecipW = 25;
  localparam int ProbW  = 16;

  localparam logic [30:0] Log2eQ30 = 31'd1549082005;
  localparam logic [31:0] Ln2Q32   = 32'd2977044472;
  localparam int FracBits = 42;

  localparam logic [6:0] RegRowLength = 7'd0;
  localparam logic [6:0] RegRowTotal  = 7'd1;

endpackage

>>> rtl/rsm_ram.sv
// ----------------------------------------------------------------------------
// rsm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rsm_recip.sv
// ----------------------------------------------------------------------------
// rsm_recip: iterative reciprocal, floor(2^40 / sum)
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsm_recip
  import rsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SumW-1:0]   sum,
  output logic              done,
  output logic [RecipW-1:0] recip
);

  localparam int Steps = 41;

  logic [5:0]      step;
  logic            busy;
  logic [SumW:0]   rem;
  logic [40:0]     quo;
  logic [SumW-1:0] dvs;
  logic [SumW:0]   shifted;
  logic [SumW:0]   diff;
  logic            bit_in;

  assign bit_in  = (step == 6'd0);
  assign shifted = {rem[SumW-1:0], bit_in};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= '0;
        dvs  <= sum;
      end else if (busy) begin
        if (!diff[SumW]) begin
          rem <= diff;
          quo <= {quo[39:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[39:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sum is at least 65536, so the quotient is at most 2^24 and fits in 25 bits.
  assign recip = quo[RecipW-1:0];

endmodule

>>> rtl/row_softmax.sv
// ----------------------------------------------------------------------------
// row_softmax: row-wise softmax over signed Q4.12 logits
// Buffers a row in RAM, then runs an exp pass, a reciprocal and a normalize
// pass, emitting one Q0.16 probability per element.
// ----------------------------------------------------------------------------
//  channel   | signals                                 | handshake
//  ----------+-----------------------------------------+-------------
//  input     | logit                                   | valid/ready
//  output    | probability, row_end, batch_end         | out_valid/out_ready
//  config    | cfg_we, cfg_index, cfg_data             | write enable
//
// Logits are loaded into the logit RAM. When a row of N logits is complete
// the exp pass runs (RAM read, multiply, table and shift, result register,
// drain check), then the reciprocal in the restoring divider, and then the
// normalize pass for each element, by way of the RAM read, the multiplier,
// the output register and the handshake.
// No logit is accepted between row close and the last result.
// Reset is synchronous; the RAMs need no clearing since only entries written
// in the current row are read. A stalled output holds its item.
// ----------------------------------------------------------------------------
module row_softmax
  import rsm_pkg::*;
#(
  parameter int MAX_COLS       = 64,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  output logic                     ready,
  input  logic signed [LogitW-1:0] logit,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ProbW-1:0]         probability,
  output logic                     row_end,
  output logic                     batch_end,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TS = 1 << EXP_TABLE_BITS;

  // Table entry i = round(65536 * 2^(-i/TS)), worked out at elaboration by
  // an alternating integer series for exp(-i*ln2/TS) in Q32.
  typedef logic [ExpW-1:0] exp_tab_t [TS];
  function automatic exp_tab_t build_tab();
    exp_tab_t tab;
    longint unsigned y, term, acc;
    for (int i = 0; i < TS; i++) begin
      y = (64'(i) * Ln2Q32) >> EXP_TABLE_BITS;
      term = 64'd1 << 32;
      acc = 64'd1 << 32;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * y) >> 32) / 64'(k);
        if ((k & 1) == 1) acc = acc - term;
        else acc = acc + term;
      end
      tab[i] = ExpW'((acc + (64'd1 << 15)) >> 16);
    end
    return tab;
  endfunction
  localparam exp_tab_t ExpTab = build_tab();

  typedef enum logic [2:0] {
    S_LOAD, S_EXP, S_RECIP, S_NORM, S_OUT
  } state_t;

  state_t state;

  logic [6:0]  row_length;
  logic [15:0] row_total;
  logic [6:0]  eff_len;
  logic [15:0] eff_total;
  logic signed [LogitW-1:0] running_max;
  logic [SumW-1:0] exp_sum;
  logic [6:0]  element_count;
  logic [15:0] row_counter;
  logic        last_row;

  always_comb begin
    if (row_length == 7'd0) eff_len = 7'd1;
    else if (row_length > 7'(MAX_COLS)) eff_len = 7'(MAX_COLS);
    else eff_len = row_length;
    eff_total = (row_total == 16'd0) ? 16'd1 : row_total;
  end

  // Write slot saturates at the last entry, as an overlong row does.
  logic [AW-1:0] load_addr;
  assign load_addr = (element_count >= 7'(MAX_COLS)) ? AW'(MAX_COLS - 1)
                                                       : element_count[AW-1:0];
  logic [6:0] count_inc;
  assign count_inc = ((element_count >= 7'(MAX_COLS)) ? 7'(MAX_COLS - 1)
                                                       : element_count) + 7'd1;

  assign ready = (state == S_LOAD);
  logic in_acc;
  assign in_acc = valid && ready;

  // Exp pass pipeline: read address, read data, product, result.
  logic [6:0]      rd_idx;
  logic            p1_v, p2_v, p3_v;
  logic [AW-1:0]   p1_a, p2_a, p3_a;
  logic [LogitW-1:0] lg_rdata;
  logic [47:0]     t_prod;
  logic [ExpW-1:0] e_val;
  logic [ExpW-1:0] e_reg;

  logic [15:0] diff_d;
  assign diff_d = 16'(running_max - $signed(lg_rdata));

  logic [5:0] n_int;
  logic [EXP_TABLE_BITS-1:0] t_idx;
  logic [ExpW-1:0] t_ent;
  assign n_int = t_prod[47:FracBits];
  assign t_idx = t_prod[FracBits-1 -: EXP_TABLE_BITS];
  assign t_ent = ExpTab[t_idx];

  always_comb begin
    if (n_int == 6'd0) e_val = t_ent;
    else if (n_int >= 6'd18) e_val = '0;
    else e_val = ExpW'(({1'b0, t_ent} + (18'd1 << (n_int - 6'd1))) >> n_int);
  end

  logic exp_we;
  logic [AW-1:0] exp_waddr;
  logic [ExpW-1:0] exp_wdata;
  logic [AW-1:0] ex_raddr;
  logic [ExpW-1:0] ex_rdata;

  rsm_ram #(.WIDTH(LogitW), .DEPTH(MAX_COLS)) u_logit_ram (
    .clk(clk), .we(in_acc), .waddr(load_addr), .wdata(logit),
    .raddr(rd_idx[AW-1:0]), .rdata(lg_rdata)
  );

  rsm_ram #(.WIDTH(ExpW), .DEPTH(MAX_COLS)) u_exp_ram (
    .clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_wdata),
    .raddr(ex_raddr), .rdata(ex_rdata)
  );

  assign exp_we    = p3_v;
  assign exp_waddr = p3_a;
  assign exp_wdata = e_reg;
  assign ex_raddr  = rd_idx[AW-1:0];

  logic recip_start, recip_done;
  logic [RecipW-1:0] recip;

  rsm_recip u_recip (
    .clk(clk), .rst(rst), .start(recip_start), .sum(exp_sum),
    .done(recip_done), .recip(recip)
  );

  logic [41:0] p_prod;
  logic [17:0] p_round;
  assign p_round = 18'((p_prod + 42'(1 << 23)) >> 24);

  logic norm_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      row_length    <= 7'd64;
      row_total     <= 16'd1;
      running_max   <= 16'sh8000;
      exp_sum       <= '0;
      element_count <= '0;
      row_counter   <= '0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      p3_v          <= 1'b0;
      recip_start   <= 1'b0;
      out_valid     <= 1'b0;
      rd_idx        <= '0;
      norm_ph       <= 1'b0;
    end else begin
      recip_start <= 1'b0;
      if (cfg_we) begin
        if (7'(cfg_index) == RegRowLength) row_length <= cfg_data[6:0];
        else row_total <= cfg_data;
      end
      p2_v <= p1_v;
      p2_a <= p1_a;
      p3_v <= p2_v;
      p3_a <= p2_a;
      t_prod <= 48'(diff_d) * 48'(Log2eQ30);
      // The result register lines the exp value up with the third stage.
      e_reg <= e_val;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (logit > running_max) running_max <= logit;
            element_count <= count_inc;
            if (count_inc >= eff_len) begin
              state   <= S_EXP;
              rd_idx  <= '0;
              exp_sum <= '0;
            end
          end
        end
        S_EXP: begin
          p1_v <= (rd_idx < element_count);
          p1_a <= rd_idx[AW-1:0];
          if (rd_idx < element_count) rd_idx <= rd_idx + 7'd1;
          if (p3_v) exp_sum <= exp_sum + SumW'(e_reg);
          if (!p1_v && !p2_v && !p3_v && rd_idx >= element_count
              && rd_idx != 7'd0) begin
            state       <= S_RECIP;
            recip_start <= 1'b1;
          end
        end
        S_RECIP: begin
          if (p3_v) exp_sum <= exp_sum + SumW'(e_reg);
          if (recip_done) begin
            state    <= S_NORM;
            rd_idx   <= '0;
            norm_ph  <= 1'b0;
            last_row <= (row_counter + 16'd1) >= eff_total;
          end
        end
        S_NORM: begin
          // Phase 0: RAM read lands. Phase 1: multiply.
          if (!norm_ph) begin
            norm_ph <= 1'b1;
          end else begin
            p_prod  <= 42'(ex_rdata) * 42'(recip);
            norm_ph <= 1'b0;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            probability <= (p_round > 18'd65535) ? 16'hFFFF : p_round[15:0];
            row_end     <= (rd_idx + 7'd1 == element_count);
            batch_end   <= (rd_idx + 7'd1 == element_count) && last_row;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (rd_idx + 7'd1 == element_count) begin
              state         <= S_LOAD;
              row_counter   <= last_row ? 16'd0 : row_counter + 16'd1;
              running_max   <= 16'sh8000;
              element_count <= '0;
              exp_sum       <= '0;
              rd_idx        <= '0;
            end else begin
              rd_idx <= rd_idx + 7'd1;
              state  <= S_NORM;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      if (state != S_EXP) p1_v <= 1'b0;
    end
  end

  // The exp store is written only in the exp pass or the reciprocal state.
  a_exp_write: assert property (@(posedge clk) disable iff (rst)
    exp_we |-> (state == S_EXP || state == S_RECIP))
    else $error("exp store written outside the exp pass");

  // No logit is taken while results of a row are pending.
  a_no_load_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready)
    else $error("input ready while a result is pending");

  // The sum is never below the maximum element's weight at normalize.
  a_sum_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM) |-> (exp_sum >= SumW'(65536)))
    else $error("exp sum below one");

  // batch_end only ever rides on row_end.
  a_batch_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && batch_end) |-> row_end)
    else $error("batch end without row end");

endmodule
